>>> rtl/url_name_extract_unit_defines.svh
// assertion macros for the url name extract unit
`ifndef URL_NAME_EXTRACT_UNIT_DEFINES_SVH
`define URL_NAME_EXTRACT_UNIT_DEFINES_SVH

// clocked check, off while reset is held
`define UNE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// clocked check that also runs through reset
`define UNE_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

>>> rtl/une_pkg.sv
// shared types, constants and helpers for the url name extract unit
package une_pkg;

    localparam int BUF_DEPTH_DEF = 64;

    localparam logic [7:0] CH_QUEST = 8'h3F;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_PCT   = 8'h25;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NO_SLASH = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_BAD_ESC  = 3'd3,
        ST_OVERFLOW = 3'd4
    } t_status;

    typedef struct packed {
        logic    load;
        logic    clear;
        logic    walk_start;
        logic    rd;
        logic    step;
        logic    emit;
        logic    err;
        t_status err_code;
    } t_cmd;

    typedef struct packed {
        logic ovf;
        logic no_slash;
        logic empty;
        logic at_stop;
        logic esc_busy;
        logic bad_hex;
        logic byte_done;
    } t_sts;

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
               (c >= 8'h41 && c <= 8'h46);
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] v;
        v = 8'h00;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = c - 8'h30;
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = c - 8'h57;
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = c - 8'h37;
        end
        return v[3:0];
    endfunction

endpackage

>>> rtl/une_ctrl.sv
// controller state machine: load, evaluate, escape check, decode and emit
module une_ctrl
    import une_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_url_valid,
    input  logic i_url_last,
    input  logic i_name_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_url_ready,
    output logic o_name_valid
);

    typedef enum logic [2:0] {
        S_LOAD,
        S_EVAL,
        S_CRD,
        S_CDAT,
        S_ERD,
        S_EDAT,
        S_OUT,
        S_ERR
    } t_state;

    t_state r_state, n_state;
    logic   r_url_ready, n_url_ready;
    logic   r_name_valid, n_name_valid;

    always_comb begin
        n_state  = r_state;
        o_cmd    = '0;
        o_cmd.err_code = ST_OK;
        case (r_state)
            S_LOAD: begin
                if (i_url_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_url_last) n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (i_sts.ovf) begin
                    o_cmd.err = 1'b1;
                    o_cmd.err_code = ST_OVERFLOW;
                    n_state = S_ERR;
                end else if (i_sts.no_slash) begin
                    o_cmd.err = 1'b1;
                    o_cmd.err_code = ST_NO_SLASH;
                    n_state = S_ERR;
                end else if (i_sts.empty) begin
                    o_cmd.err = 1'b1;
                    o_cmd.err_code = ST_EMPTY;
                    n_state = S_ERR;
                end else begin
                    o_cmd.walk_start = 1'b1;
                    n_state = S_CRD;
                end
            end
            S_CRD: begin
                if (i_sts.at_stop) begin
                    if (i_sts.esc_busy) begin
                        o_cmd.err = 1'b1;
                        o_cmd.err_code = ST_BAD_ESC;
                        n_state = S_ERR;
                    end else begin
                        o_cmd.walk_start = 1'b1;
                        n_state = S_ERD;
                    end
                end else begin
                    o_cmd.rd = 1'b1;
                    n_state = S_CDAT;
                end
            end
            S_CDAT: begin
                if (i_sts.bad_hex) begin
                    o_cmd.err = 1'b1;
                    o_cmd.err_code = ST_BAD_ESC;
                    n_state = S_ERR;
                end else begin
                    o_cmd.step = 1'b1;
                    n_state = S_CRD;
                end
            end
            S_ERD: begin
                o_cmd.rd = 1'b1;
                n_state = S_EDAT;
            end
            S_EDAT: begin
                o_cmd.step = 1'b1;
                o_cmd.emit = 1'b1;
                n_state = i_sts.byte_done ? S_OUT : S_ERD;
            end
            S_OUT: begin
                if (i_name_ready) begin
                    if (i_sts.at_stop) begin
                        o_cmd.clear = 1'b1;
                        n_state = S_LOAD;
                    end else begin
                        n_state = S_ERD;
                    end
                end
            end
            S_ERR: begin
                if (i_name_ready) begin
                    o_cmd.clear = 1'b1;
                    n_state = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
        n_url_ready  = (n_state == S_LOAD);
        n_name_valid = (n_state == S_OUT) || (n_state == S_ERR);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_LOAD;
            r_url_ready  <= 1'b1;
            r_name_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_url_ready  <= n_url_ready;
            r_name_valid <= n_name_valid;
        end
    end

    assign o_url_ready  = r_url_ready;
    assign o_name_valid = r_name_valid;

endmodule

>>> rtl/une_datapath.sv
// datapath: text buffer, position tracking, escape walk and result register
module une_datapath
    import une_pkg::*;
#(
    parameter int BUF_DEPTH = BUF_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_cmd,
    input  logic [7:0] i_url_byte,
    output t_sts       o_sts,
    output logic [7:0] o_name_byte,
    output logic       o_name_last,
    output logic [2:0] o_status
);

    localparam int ADDR_W = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
    localparam int CNT_W  = $clog2(BUF_DEPTH + 1);

    typedef enum logic [1:0] {
        ESC_NONE,
        ESC_HI,
        ESC_LO
    } t_esc;

    logic [7:0]       r_mem [BUF_DEPTH];
    logic [CNT_W-1:0] r_wc;
    logic             r_cut_found;
    logic [CNT_W-1:0] r_cut_pos;
    logic [CNT_W-1:0] r_seg;
    logic [CNT_W-1:0] r_dot;
    logic             r_dot_seen;
    logic             r_ovf;
    logic [CNT_W-1:0] r_cur;
    t_esc             r_esc;
    logic [3:0]       r_acc;
    logic [7:0]       r_rd_data;
    logic [7:0]       r_name_byte;
    logic             r_name_last;
    t_status          r_status;

    logic [CNT_W-1:0] w_end;
    logic [CNT_W-1:0] w_stop;
    logic             w_full;
    logic             w_byte_done;

    assign w_end  = r_cut_found ? r_cut_pos : r_wc;
    assign w_stop = r_dot_seen ? r_dot : w_end;
    assign w_full = (r_wc == CNT_W'(BUF_DEPTH));
    assign w_byte_done = ((r_esc == ESC_NONE) && (r_rd_data != CH_PCT)) || (r_esc == ESC_LO);

    always_comb begin
        o_sts.ovf       = r_ovf;
        o_sts.no_slash  = (r_seg == '0);
        o_sts.empty     = (w_stop <= r_seg);
        o_sts.at_stop   = (r_cur == w_stop);
        o_sts.esc_busy  = (r_esc != ESC_NONE);
        o_sts.bad_hex   = (r_esc != ESC_NONE) && !is_hex(r_rd_data);
        o_sts.byte_done = w_byte_done;
    end

    // buffer
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && !r_ovf && !w_full) begin
            r_mem[r_wc[ADDR_W-1:0]] <= i_url_byte;
        end
        if (i_cmd.rd) begin
            r_rd_data <= r_mem[r_cur[ADDR_W-1:0]];
        end
    end

    // tracking and walk control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_wc        <= '0;
            r_cut_found <= 1'b0;
            r_cut_pos   <= '0;
            r_seg       <= '0;
            r_dot       <= '0;
            r_dot_seen  <= 1'b0;
            r_ovf       <= 1'b0;
            r_cur       <= '0;
            r_esc       <= ESC_NONE;
        end else begin
            if (i_cmd.load && !r_ovf) begin
                if (w_full) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_wc <= r_wc + CNT_W'(1);
                    if (!r_cut_found) begin
                        if (i_url_byte == CH_QUEST || i_url_byte == CH_HASH) begin
                            r_cut_found <= 1'b1;
                            r_cut_pos   <= r_wc;
                        end else if (i_url_byte == CH_SLASH) begin
                            r_seg      <= r_wc + CNT_W'(1);
                            r_dot_seen <= 1'b0;
                        end else if (i_url_byte == CH_DOT) begin
                            r_dot      <= r_wc;
                            r_dot_seen <= 1'b1;
                        end
                    end
                end
            end
            if (i_cmd.walk_start) begin
                r_cur <= r_seg;
                r_esc <= ESC_NONE;
            end else if (i_cmd.rd) begin
                r_cur <= r_cur + CNT_W'(1);
            end
            if (i_cmd.step) begin
                case (r_esc)
                    ESC_NONE: r_esc <= (r_rd_data == CH_PCT) ? ESC_HI : ESC_NONE;
                    ESC_HI:   r_esc <= ESC_LO;
                    ESC_LO:   r_esc <= ESC_NONE;
                    default:  r_esc <= ESC_NONE;
                endcase
            end
        end
    end

    // decode and result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.step && r_esc == ESC_HI) begin
            r_acc <= hex_val(r_rd_data);
        end
        if (i_cmd.err) begin
            r_name_byte <= 8'h00;
            r_name_last <= 1'b1;
            r_status    <= i_cmd.err_code;
        end else if (i_cmd.emit && w_byte_done) begin
            r_name_byte <= (r_esc == ESC_LO) ? {r_acc, hex_val(r_rd_data)} : r_rd_data;
            r_name_last <= (r_cur == w_stop);
            r_status    <= ST_OK;
        end
    end

    assign o_name_byte = r_name_byte;
    assign o_name_last = r_name_last;
    assign o_status    = r_status;

endmodule

>>> rtl/url_name_extract_unit.sv
// top level of the url name extract unit
// loading: one url byte per cycle, input held off from the last byte until the url is finished
// after the last byte: an evaluate state, then an escape check that reads each name byte in turn,
// then a decode pass that reads each raw name byte again and emits one result item per decoded byte
// an error item follows the evaluate state, or the escape check state in which the check fails
// synchronous active-low reset clears control and tracking; the text buffer is not cleared
module url_name_extract_unit
    import une_pkg::*;
#(
    parameter int BUF_DEPTH = BUF_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_url_valid,
    output logic       o_url_ready,
    input  logic [7:0] i_url_byte,
    input  logic       i_url_last,
    output logic       o_name_valid,
    input  logic       i_name_ready,
    output logic [7:0] o_name_byte,
    output logic       o_name_last,
    output logic [2:0] o_status
);

    t_cmd w_cmd;
    t_sts w_sts;

    une_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_url_valid  (i_url_valid),
        .i_url_last   (i_url_last),
        .i_name_ready (i_name_ready),
        .i_sts        (w_sts),
        .o_cmd        (w_cmd),
        .o_url_ready  (o_url_ready),
        .o_name_valid (o_name_valid)
    );

    une_datapath #(
        .BUF_DEPTH (BUF_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_url_byte  (i_url_byte),
        .o_sts       (w_sts),
        .o_name_byte (o_name_byte),
        .o_name_last (o_name_last),
        .o_status    (o_status)
    );

endmodule

>>> rtl/une_checker.sv
// port-level assertions for the url name extract unit
`include "url_name_extract_unit_defines.svh"

module une_checker
    import une_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_url_valid,
    input logic       o_url_ready,
    input logic [7:0] i_url_byte,
    input logic       i_url_last,
    input logic       o_name_valid,
    input logic       i_name_ready,
    input logic [7:0] o_name_byte,
    input logic       o_name_last,
    input logic [2:0] o_status
);

    `UNE_ASSERT(a_out_hold, o_name_valid && !i_name_ready |=> o_name_valid && $stable(o_name_byte) && $stable(o_status) && $stable(o_name_last), "result item changed while stalled")
    `UNE_ASSERT(a_no_overlap, o_name_valid |-> !o_url_ready, "url byte taken while a result waits")
    `UNE_ASSERT(a_err_item, o_name_valid && o_status != ST_OK |-> o_name_last && o_name_byte == 8'h00, "error item not final or not zero")
    `UNE_ASSERT(a_last_ready, o_url_ready && i_url_valid && i_url_last |=> !o_url_ready, "input open after the final url byte")
    `UNE_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> !o_name_valid && o_url_ready, "not idle after reset")

endmodule

bind url_name_extract_unit une_checker u_une_checker (.*);
